// ===== rtl/assert_macros.svh =====
// Assertion helpers used by rtl/hash_map_linear_probe.sv.
// Every check samples on the block clock and is disabled while reset is asserted.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/hmlp_pkg.sv =====
`default_nettype none

package hmlp_pkg;

  // Fixed field widths of the request and response words.
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned LEN_W    = 5;
  localparam int unsigned KEY64_W  = 64;
  localparam int unsigned KEY32_W  = 32;
  localparam int unsigned KEY_IN_W = 2 * KEY64_W + KEY32_W;

  // Hash step h = h * 31 + c, with bytes taken as 0 to 255.
  localparam int unsigned HASH_MULT = 31;
  localparam int unsigned BYTE_MAX  = 255;

  // Value returned by a lookup that misses.
  localparam logic signed [VALUE_W-1:0] MISS_VALUE = -32'sd1;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_LOOKUP = 1'b1
  } opcode_e;

  // Operation and value carried from the request to the probe sequencer.
  typedef struct packed {
    logic               lookup;
    logic [VALUE_W-1:0] value;
  } hmlp_req_t;

  // Result of one probe walk.
  typedef struct packed {
    logic signed [VALUE_W-1:0] found_value;
    logic                      found;
    logic                      status;
  } hmlp_result_t;

  typedef enum logic [1:0] {
    T_IDLE,
    T_HASH,
    T_PROBE,
    T_OUT
  } top_state_e;

  typedef enum logic [1:0] {
    H_IDLE,
    H_BYTE,
    H_RED,
    H_FIN
  } hash_state_e;

  typedef enum logic [2:0] {
    P_CLEAR,
    P_IDLE,
    P_READ,
    P_CHECK,
    P_DONE
  } probe_state_e;

endpackage

`default_nettype wire

// ===== rtl/hmlp_req_if.sv =====
`default_nettype none

interface hmlp_req_if;
  import hmlp_pkg::*;

  logic                       valid;
  logic                       ready;
  logic                       opcode;
  logic [KEY64_W-1:0]         key_bytes_first;
  logic [KEY64_W-1:0]         key_bytes_middle;
  logic [KEY32_W-1:0]         key_bytes_last;
  logic [LEN_W-1:0]           key_length;
  logic signed [VALUE_W-1:0]  new_value;

  modport source (
    output valid, opcode, key_bytes_first, key_bytes_middle, key_bytes_last,
           key_length, new_value,
    input  ready
  );

  modport sink (
    input  valid, opcode, key_bytes_first, key_bytes_middle, key_bytes_last,
           key_length, new_value,
    output ready
  );

endinterface

interface hmlp_rsp_if;
  import hmlp_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] found_value;
  logic                      found;
  logic                      status;

  modport source (
    output valid, found_value, found, status,
    input  ready
  );

  modport sink (
    input  valid, found_value, found, status,
    output ready
  );

endinterface

`default_nettype wire

// ===== rtl/hmlp_hash.sv =====
`default_nettype none

// Home slot of a key: h = (h * 31 + c) mod TABLE_DEPTH over the key bytes.
// Each byte forms 31h + c in H_BYTE and is then reduced in H_RED on the shared
// reduction unit, which takes the remainder by a reciprocal multiply and a
// single correcting subtract.
module hmlp_hash #(
  parameter int unsigned TABLE_DEPTH = 4096,
  parameter int unsigned KEY_BYTES   = 20
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  input  wire logic [hmlp_pkg::BYTE_W*KEY_BYTES-1:0] key_i,
  input  wire logic [hmlp_pkg::LEN_W-1:0]            key_len_i,
  output logic                                       done_o,
  output logic [$clog2(TABLE_DEPTH)-1:0]             home_o,
  output logic [hmlp_pkg::BYTE_W*KEY_BYTES-1:0]      key_o
);
  import hmlp_pkg::*;

  localparam int unsigned KEY_W   = BYTE_W * KEY_BYTES;
  localparam int unsigned SLOT_W  = $clog2(TABLE_DEPTH);
  localparam int unsigned IDX_W   = $clog2(KEY_BYTES + 1);
  localparam int unsigned V_MAX   = HASH_MULT * (TABLE_DEPTH - 1) + BYTE_MAX;
  localparam int unsigned V_W     = $clog2(V_MAX + 1);
  localparam int unsigned RECIP   = (32'd1 << V_W) / TABLE_DEPTH;
  localparam int unsigned RECIP_W = $clog2(RECIP + 1);
  localparam int unsigned PROD_W  = V_W + RECIP_W;

  hash_state_e        state_q, state_d;
  logic [KEY_W-1:0]   key_q;
  logic [IDX_W-1:0]   len_q;
  logic [IDX_W-1:0]   idx_q;
  logic [SLOT_W-1:0]  h_q;
  logic [V_W-1:0]     rem_q;

  logic [BYTE_W-1:0]  cur_byte;
  logic               key_end;
  logic [KEY_W-1:0]   key_masked;
  logic [V_W-1:0]     v_new;
  logic [PROD_W-1:0]  prod;
  logic [RECIP_W-1:0] q_est;
  logic [V_W-1:0]     r_est;
  logic [V_W-1:0]     rem_next;
  logic [IDX_W-1:0]   len_clip;

  // Current byte, and the key with every byte from the end point on cleared.
  always_comb begin
    cur_byte   = '0;
    key_masked = '0;
    for (int j = 0; j < KEY_BYTES; j++) begin
      if (idx_q == IDX_W'(j)) begin
        cur_byte = key_q[BYTE_W*j +: BYTE_W];
      end
      if (IDX_W'(j) < idx_q) begin
        key_masked[BYTE_W*j +: BYTE_W] = key_q[BYTE_W*j +: BYTE_W];
      end
    end
  end

  // The key ends at its length or at its first zero byte.
  assign key_end  = (idx_q >= len_q) || (cur_byte == '0);
  assign len_clip = (key_len_i > LEN_W'(KEY_BYTES)) ? IDX_W'(KEY_BYTES) : IDX_W'(key_len_i);

  // Multiply-accumulate of the next byte.
  assign v_new    = V_W'(h_q) * V_W'(HASH_MULT) + V_W'(cur_byte);

  // Shared reduction unit: the reciprocal estimate of the quotient is low by at
  // most one, so one compare-subtract finishes the remainder.
  assign prod     = PROD_W'(rem_q) * PROD_W'(RECIP);
  assign q_est    = prod[PROD_W-1:V_W];
  assign r_est    = rem_q - V_W'(q_est) * V_W'(TABLE_DEPTH);
  assign rem_next = (r_est >= V_W'(TABLE_DEPTH)) ? (r_est - V_W'(TABLE_DEPTH)) : r_est;

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      H_IDLE: begin
        if (start_i) state_d = H_BYTE;
      end
      H_BYTE: begin
        state_d = key_end ? H_FIN : H_RED;
      end
      H_RED: begin
        state_d = H_BYTE;
      end
      H_FIN: begin
        state_d = H_IDLE;
      end
      default: state_d = H_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    done_o = (state_q == H_FIN);
    home_o = h_q;
    key_o  = key_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= H_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    case (state_q)
      H_IDLE: begin
        if (start_i) begin
          key_q <= key_i;
          len_q <= len_clip;
          idx_q <= '0;
          h_q   <= '0;
        end
      end
      H_BYTE: begin
        if (key_end) begin
          key_q <= key_masked;
        end else begin
          rem_q <= v_new;
        end
      end
      H_RED: begin
        h_q   <= rem_next[SLOT_W-1:0];
        idx_q <= idx_q + IDX_W'(1);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/hmlp_probe.sv =====
`default_nettype none

// Slot memory and linear probe sequencer. Each slot holds its occupied mark,
// key and value in one word. After reset a sweep clears every occupied mark.
module hmlp_probe #(
  parameter int unsigned TABLE_DEPTH = 4096,
  parameter int unsigned KEY_BYTES   = 20
) (
  input  wire logic                                  clk_i,
  input  wire logic                                  rst_ni,
  input  wire logic                                  start_i,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0]        home_i,
  input  wire logic [hmlp_pkg::BYTE_W*KEY_BYTES-1:0] key_i,
  input  wire hmlp_pkg::hmlp_req_t                   req_i,
  output logic                                       ready_o,
  output logic                                       done_o,
  output hmlp_pkg::hmlp_result_t                     result_o
);
  import hmlp_pkg::*;

  localparam int unsigned KEY_W  = BYTE_W * KEY_BYTES;
  localparam int unsigned SLOT_W = $clog2(TABLE_DEPTH);
  localparam int unsigned ENT_W  = 1 + KEY_W + VALUE_W;

  probe_state_e       state_q, state_d;
  logic [SLOT_W-1:0]  clr_q;
  logic [SLOT_W-1:0]  idx_q;
  logic [SLOT_W-1:0]  cnt_q;
  logic [KEY_W-1:0]   key_q;
  hmlp_req_t          req_q;
  hmlp_result_t       res_q;
  logic [ENT_W-1:0]   rdata_q;
  logic [ENT_W-1:0]   mem_q [TABLE_DEPTH];

  logic               ent_occ;
  logic [KEY_W-1:0]   ent_key;
  logic [VALUE_W-1:0] ent_val;
  logic               hit;
  logic               stop;
  logic               last;
  logic               clr_end;
  logic [SLOT_W-1:0]  idx_inc;
  logic               we;
  logic [SLOT_W-1:0]  waddr;
  logic [ENT_W-1:0]   wdata;

  // Fields of the slot read in the previous cycle.
  assign ent_occ = rdata_q[ENT_W-1];
  assign ent_key = rdata_q[VALUE_W +: KEY_W];
  assign ent_val = rdata_q[VALUE_W-1:0];

  // The walk stops at an empty slot or a matching key; the last visit ends it anyway.
  assign hit     = ent_occ && (ent_key == key_q);
  assign stop    = !ent_occ || hit;
  assign last    = (cnt_q == SLOT_W'(TABLE_DEPTH - 1));
  assign clr_end = (clr_q == SLOT_W'(TABLE_DEPTH - 1));
  assign idx_inc = (idx_q == SLOT_W'(TABLE_DEPTH - 1)) ? '0 : (idx_q + SLOT_W'(1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      P_CLEAR: begin
        if (clr_end) state_d = P_IDLE;
      end
      P_IDLE: begin
        if (start_i) state_d = P_READ;
      end
      P_READ: begin
        state_d = P_CHECK;
      end
      P_CHECK: begin
        state_d = (stop || last) ? P_DONE : P_READ;
      end
      P_DONE: begin
        state_d = P_IDLE;
      end
      default: state_d = P_IDLE;
    endcase
  end

  // Outputs and the memory write port.
  always_comb begin
    ready_o  = (state_q == P_IDLE);
    done_o   = (state_q == P_DONE);
    result_o = res_q;
    we       = 1'b0;
    waddr    = idx_q;
    wdata    = {1'b1, key_q, req_q.value};
    unique case (state_q)
      P_CLEAR: begin
        we    = 1'b1;
        waddr = clr_q;
        wdata = '0;
      end
      P_CHECK: begin
        we = stop && !req_q.lookup;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= P_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == P_CLEAR) begin
        clr_q <= clr_q + SLOT_W'(1);
      end
    end
  end

  // Slot memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[idx_q];
  end

  // Probe registers and the result word.
  always_ff @(posedge clk_i) begin
    case (state_q)
      P_IDLE: begin
        if (start_i) begin
          idx_q <= home_i;
          key_q <= key_i;
          req_q <= req_i;
          cnt_q <= '0;
        end
      end
      P_CHECK: begin
        if (stop || last) begin
          res_q.status <= !stop;
          if (req_q.lookup) begin
            res_q.found_value <= hit ? $signed(ent_val) : MISS_VALUE;
            res_q.found       <= hit;
          end else begin
            res_q.found_value <= '0;
            res_q.found       <= 1'b0;
          end
        end else begin
          idx_q <= idx_inc;
          cnt_q <= cnt_q + SLOT_W'(1);
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/hash_map_linear_probe.sv =====
// Flow: a request word is hashed over its key bytes (each byte formed, then reduced), and the
// slots are then probed from the home slot (each slot read, then checked) before the result
// is registered as the response word.
// Throughput: one word in flight; the next request is taken once the response is registered.
// Reset: a sweep clears the occupied mark of every slot, one per cycle, and the request side is
// not ready until it ends.
`default_nettype none

`include "assert_macros.svh"

module hash_map_linear_probe #(
  parameter int unsigned TABLE_DEPTH = 4096,
  parameter int unsigned KEY_BYTES   = 20
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  hmlp_req_if.sink    req_i,
  hmlp_rsp_if.source  rsp_o
);
  import hmlp_pkg::*;

  localparam int unsigned KEY_W  = BYTE_W * KEY_BYTES;
  localparam int unsigned SLOT_W = $clog2(TABLE_DEPTH);

  top_state_e          state_q, state_d;
  hmlp_req_t           req_q;
  logic                out_valid_q;
  hmlp_result_t        out_res_q;

  logic [KEY_IN_W-1:0] key_all;
  logic                accept;
  logic                slot_free;
  logic                probe_start;
  logic                out_load;
  logic                hash_done;
  logic [SLOT_W-1:0]   hash_home;
  logic [KEY_W-1:0]    hash_key;
  logic                probe_ready;
  logic                probe_done;
  hmlp_result_t        probe_res;

  assign key_all = {req_i.key_bytes_last, req_i.key_bytes_middle, req_i.key_bytes_first};

  hmlp_hash #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BYTES   (KEY_BYTES)
  ) u_hash (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .key_i     (key_all[KEY_W-1:0]),
    .key_len_i (req_i.key_length),
    .done_o    (hash_done),
    .home_o    (hash_home),
    .key_o     (hash_key)
  );

  hmlp_probe #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .KEY_BYTES   (KEY_BYTES)
  ) u_probe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (probe_start),
    .home_i   (hash_home),
    .key_i    (hash_key),
    .req_i    (req_q),
    .ready_o  (probe_ready),
    .done_o   (probe_done),
    .result_o (probe_res)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      T_IDLE: begin
        if (accept) state_d = T_HASH;
      end
      T_HASH: begin
        if (hash_done) state_d = T_PROBE;
      end
      T_PROBE: begin
        if (probe_done) state_d = slot_free ? T_IDLE : T_OUT;
      end
      T_OUT: begin
        if (slot_free) state_d = T_IDLE;
      end
      default: state_d = T_IDLE;
    endcase
  end

  // Handshakes and phase strobes.
  always_comb begin
    req_i.ready = (state_q == T_IDLE) && probe_ready;
    accept      = req_i.valid && req_i.ready;
    slot_free   = !out_valid_q || rsp_o.ready;
    probe_start = (state_q == T_HASH) && hash_done;
    out_load    = slot_free && (((state_q == T_PROBE) && probe_done) || (state_q == T_OUT));
  end

  // Response word.
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.found_value = out_res_q.found_value;
  assign rsp_o.found       = out_res_q.found;
  assign rsp_o.status      = out_res_q.status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request fields kept for the probe, and the registered result.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q.lookup <= (req_i.opcode == OP_LOOKUP);
      req_q.value  <= req_i.new_value;
    end
    if (out_load) begin
      out_res_q <= probe_res;
    end
  end

  `ASSERT_IMP(a_hash_done_in_hash, hash_done, state_q == T_HASH, "hash finished outside hashing")
  `ASSERT_IMP(a_probe_done_in_probe, probe_done, state_q == T_PROBE, "probe ended outside probing")
  `ASSERT_NXT(a_one_word_in_flight, accept, !req_i.ready, "request taken while a word is in flight")

endmodule

`default_nettype wire
